FILE: rtl/core/gif_lzw_decoder_core_macros.svh
// Assertion macros shared by the decoder core.
// They sample on clk and hold off while rst_n is low.
`ifndef GIF_LZW_DECODER_CORE_MACROS_SVH
`define GIF_LZW_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define GLD_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define GLD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define GLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GLD_ASSERT_ALWAYS(lbl, expr, msg)
`define GLD_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define GLD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/gld_pkg.sv
package gld_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int TABLE_SIZE    = 1 << MAX_CODE_BITS;
    localparam int SP_W          = MAX_CODE_BITS + 1;

    // item kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // result status codes
    localparam logic [2:0] ST_ACCEPT   = 3'd0;
    localparam logic [2:0] ST_PIXEL    = 3'd1;
    localparam logic [2:0] ST_NEED     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_END      = 3'd4;
    localparam logic [2:0] ST_BAD_CODE = 3'd5;
    localparam logic [2:0] ST_BAD_SIZE = 3'd6;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_BAD_SIZE,
        OP_PUSH_BYTE,
        OP_POP_RD,
        OP_CODE,
        OP_CHAIN_RD,
        OP_CHAIN_PUSH,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [1:0] {
        PIX_ZERO,
        PIX_CODE,
        PIX_STACK
    } pix_sel_t;

    typedef struct packed {
        dp_op_t     op;
        logic       emit;
        logic [2:0] status;
        pix_sel_t   pix_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic size_bad;
        logic buf_full;
        logic ended;
        logic sp_zero;
        logic bits_short;
        logic code_clear;
        logic code_eoi;
        logic code_bad;
        logic fresh;
        logic chain_more;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: rtl/core/gld_in_if.sv
interface gld_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [3:0] min_code_size;

    modport source (output valid, kind, data_byte, min_code_size, input ready);
    modport sink (input valid, kind, data_byte, min_code_size, output ready);
endinterface

FILE: rtl/core/gld_out_if.sv
interface gld_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] pixel_index;

    modport source (output valid, status, pixel_index, input ready);
    modport sink (input valid, status, pixel_index, output ready);
endinterface

FILE: rtl/core/gld_ctrl.sv
module gld_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       in_kind,
    output logic             in_ready,
    input  gld_pkg::dp_stat_t stat,
    output gld_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CHAIN,
        S_CHAIN_WAIT,
        S_POP,
        S_POP_WAIT
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE) && stat.out_free;

    // sequencing and command decode
    always_comb
    begin
        state_next  = state_reg;
        cmd.op      = gld_pkg::OP_NONE;
        cmd.emit    = 1'b0;
        cmd.status  = gld_pkg::ST_ACCEPT;
        cmd.pix_sel = gld_pkg::PIX_ZERO;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (in_kind)
                        gld_pkg::KIND_START:
                        begin
                            cmd.emit = 1'b1;
                            if (stat.size_bad)
                            begin
                                cmd.op     = gld_pkg::OP_BAD_SIZE;
                                cmd.status = gld_pkg::ST_BAD_SIZE;
                            end
                            else
                            begin
                                cmd.op = gld_pkg::OP_START;
                            end
                        end
                        gld_pkg::KIND_DATA:
                        begin
                            cmd.op     = gld_pkg::OP_PUSH_BYTE;
                            cmd.emit   = 1'b1;
                            cmd.status = stat.buf_full ? gld_pkg::ST_FULL : gld_pkg::ST_ACCEPT;
                        end
                        gld_pkg::KIND_READ:
                        begin
                            if (stat.ended)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.status = gld_pkg::ST_END;
                            end
                            else if (!stat.sp_zero)
                            begin
                                cmd.op     = gld_pkg::OP_POP_RD;
                                state_next = S_POP_WAIT;
                            end
                            else
                            begin
                                state_next = S_DECODE;
                            end
                        end
                        default:
                        begin
                            cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            S_DECODE:
            begin
                if (stat.out_free)
                begin
                    if (stat.bits_short)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.status = gld_pkg::ST_NEED;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.op = gld_pkg::OP_CODE;
                        if (stat.code_clear)
                        begin
                            state_next = S_DECODE;
                        end
                        else if (stat.code_eoi)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = gld_pkg::ST_END;
                            state_next = S_IDLE;
                        end
                        else if (stat.code_bad)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = gld_pkg::ST_BAD_CODE;
                            state_next = S_IDLE;
                        end
                        else if (stat.fresh)
                        begin
                            cmd.emit    = 1'b1;
                            cmd.status  = gld_pkg::ST_PIXEL;
                            cmd.pix_sel = gld_pkg::PIX_CODE;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_CHAIN;
                        end
                    end
                end
            end
            S_CHAIN:
            begin
                if (stat.chain_more)
                begin
                    cmd.op     = gld_pkg::OP_CHAIN_RD;
                    state_next = S_CHAIN_WAIT;
                end
                else
                begin
                    cmd.op     = gld_pkg::OP_FINISH;
                    state_next = S_POP;
                end
            end
            S_CHAIN_WAIT:
            begin
                cmd.op     = gld_pkg::OP_CHAIN_PUSH;
                state_next = S_CHAIN;
            end
            S_POP:
            begin
                cmd.op     = gld_pkg::OP_POP_RD;
                state_next = S_POP_WAIT;
            end
            S_POP_WAIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.status  = gld_pkg::ST_PIXEL;
                    cmd.pix_sel = gld_pkg::PIX_STACK;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/gld_dpath.sv
`include "gif_lzw_decoder_core_macros.svh"

module gld_dpath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        data_byte,
    input  logic [3:0]        min_code_size,
    input  gld_pkg::dp_cmd_t  cmd,
    output gld_pkg::dp_stat_t stat,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [2:0]        out_status,
    output logic [7:0]        out_pixel
);

    localparam int AW = gld_pkg::MAX_CODE_BITS;
    localparam int SW = gld_pkg::SP_W;
    localparam logic [SW-1:0] TBL_END = SW'(gld_pkg::TABLE_SIZE);

    logic [31:0]   bit_buf_reg, bit_buf_next;
    logic [5:0]    bit_cnt_reg, bit_cnt_next;
    logic [3:0]    base_size_reg, base_size_next;
    logic [3:0]    code_width_reg, code_width_next;
    logic [SW-1:0] nfc_reg, nfc_next;
    logic [SW-1:0] wlim_reg, wlim_next;
    logic [7:0]    first_char_reg, first_char_next;
    logic [AW-1:0] prev_code_reg, prev_code_next;
    logic [AW-1:0] incode_reg, incode_next;
    logic [AW-1:0] cur_code_reg, cur_code_next;
    logic          fresh_reg, fresh_next;
    logic          ended_reg, ended_next;
    logic [SW-1:0] sp_reg, sp_next;
    logic          out_valid_reg;
    logic [2:0]    out_status_reg;
    logic [7:0]    out_pixel_reg;

    // prefix in the upper bits, suffix in the low byte
    logic [AW+7:0] tbl_mem [gld_pkg::TABLE_SIZE];
    logic [AW+7:0] tbl_rd_reg;
    logic [7:0]    stk_mem [gld_pkg::TABLE_SIZE];
    logic [7:0]    stk_rd_reg;

    logic [SW-1:0] reset_code;
    logic [31:0]   code_mask;
    logic [AW-1:0] code_val;
    logic [SW-1:0] code_ext;
    logic [SW-1:0] nfc_inc;
    logic          push_en;
    logic [7:0]    push_data;
    logic          pop_en;
    logic          tbl_wr_en;
    logic          tbl_rd_en;
    logic          out_free;

    // next code from the bit buffer, low bits first
    assign reset_code = SW'(1) << base_size_reg;
    assign code_mask  = (32'd1 << code_width_reg) - 32'd1;
    assign code_val   = AW'(bit_buf_reg & code_mask);
    assign code_ext   = SW'(code_val);
    assign nfc_inc    = nfc_reg + SW'(1);
    assign out_free   = !out_valid_reg || out_ready;

    assign stat.size_bad   = (min_code_size < 4'd2) || (min_code_size > 4'd8);
    assign stat.buf_full   = bit_cnt_reg > 6'd24;
    assign stat.ended      = ended_reg;
    assign stat.sp_zero    = sp_reg == '0;
    assign stat.bits_short = bit_cnt_reg < 6'(code_width_reg);
    assign stat.code_clear = code_ext == reset_code;
    assign stat.code_eoi   = code_ext == reset_code + SW'(1);
    assign stat.code_bad   = fresh_reg ? (code_ext > reset_code + SW'(1)) : (code_ext > nfc_reg);
    assign stat.fresh      = fresh_reg;
    assign stat.chain_more = SW'(cur_code_reg) >= reset_code;
    assign stat.out_free   = out_free;

    // state update per command
    always_comb
    begin
        bit_buf_next    = bit_buf_reg;
        bit_cnt_next    = bit_cnt_reg;
        base_size_next  = base_size_reg;
        code_width_next = code_width_reg;
        nfc_next        = nfc_reg;
        wlim_next       = wlim_reg;
        first_char_next = first_char_reg;
        prev_code_next  = prev_code_reg;
        incode_next     = incode_reg;
        cur_code_next   = cur_code_reg;
        fresh_next      = fresh_reg;
        ended_next      = ended_reg;
        sp_next         = sp_reg;
        push_en         = 1'b0;
        push_data       = first_char_reg;
        pop_en          = 1'b0;
        tbl_wr_en       = 1'b0;
        tbl_rd_en       = 1'b0;
        case (cmd.op)
            gld_pkg::OP_START:
            begin
                base_size_next  = min_code_size;
                bit_buf_next    = '0;
                bit_cnt_next    = '0;
                first_char_next = '0;
                prev_code_next  = '0;
                code_width_next = min_code_size + 4'd1;
                nfc_next        = (SW'(1) << min_code_size) + SW'(2);
                wlim_next       = SW'(1) << (min_code_size + 4'd1);
                sp_next         = '0;
                fresh_next      = 1'b1;
                ended_next      = 1'b0;
            end
            gld_pkg::OP_BAD_SIZE:
            begin
                ended_next = 1'b1;
            end
            gld_pkg::OP_PUSH_BYTE:
            begin
                if (bit_cnt_reg <= 6'd24)
                begin
                    bit_buf_next = bit_buf_reg | (32'(data_byte) << bit_cnt_reg);
                    bit_cnt_next = bit_cnt_reg + 6'd8;
                end
            end
            gld_pkg::OP_POP_RD:
            begin
                pop_en  = 1'b1;
                sp_next = sp_reg - SW'(1);
            end
            gld_pkg::OP_CODE:
            begin
                bit_buf_next = bit_buf_reg >> code_width_reg;
                bit_cnt_next = bit_cnt_reg - 6'(code_width_reg);
                if (stat.code_clear)
                begin
                    code_width_next = base_size_reg + 4'd1;
                    nfc_next        = reset_code + SW'(2);
                    wlim_next       = reset_code << 1;
                    sp_next         = '0;
                    fresh_next      = 1'b1;
                end
                else if (stat.code_eoi || stat.code_bad)
                begin
                    ended_next = 1'b1;
                    sp_next    = '0;
                end
                else if (fresh_reg)
                begin
                    fresh_next      = 1'b0;
                    first_char_next = code_val[7:0];
                    prev_code_next  = code_val;
                end
                else
                begin
                    incode_next = code_val;
                    if (code_ext == nfc_reg)
                    begin
                        push_en       = 1'b1;
                        cur_code_next = prev_code_reg;
                    end
                    else
                    begin
                        cur_code_next = code_val;
                    end
                end
            end
            gld_pkg::OP_CHAIN_RD:
            begin
                tbl_rd_en = 1'b1;
            end
            gld_pkg::OP_CHAIN_PUSH:
            begin
                push_en       = 1'b1;
                push_data     = tbl_rd_reg[7:0];
                cur_code_next = tbl_rd_reg[AW+7:8];
            end
            gld_pkg::OP_FINISH:
            begin
                first_char_next = cur_code_reg[7:0];
                push_en         = 1'b1;
                push_data       = cur_code_reg[7:0];
                prev_code_next  = incode_reg;
                if (nfc_reg < TBL_END)
                begin
                    tbl_wr_en = 1'b1;
                    nfc_next  = nfc_inc;
                    if ((nfc_inc >= wlim_reg) && (wlim_reg < TBL_END))
                    begin
                        wlim_next       = wlim_reg << 1;
                        code_width_next = code_width_reg + 4'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        // pushes stop once the stack is full
        if (push_en && (sp_reg < TBL_END))
        begin
            sp_next = sp_reg + SW'(1);
        end
    end

    // code table
    always_ff @(posedge clk)
    begin
        if (tbl_wr_en)
        begin
            tbl_mem[nfc_reg[AW-1:0]] <= {prev_code_reg, cur_code_reg[7:0]};
        end
        if (tbl_rd_en)
        begin
            tbl_rd_reg <= tbl_mem[cur_code_reg];
        end
    end

    // output stack
    always_ff @(posedge clk)
    begin
        if (push_en && (sp_reg < TBL_END))
        begin
            stk_mem[sp_reg[AW-1:0]] <= push_data;
        end
        if (pop_en)
        begin
            stk_rd_reg <= stk_mem[sp_next[AW-1:0]];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_buf_reg    <= '0;
            bit_cnt_reg    <= '0;
            base_size_reg  <= '0;
            code_width_reg <= '0;
            nfc_reg        <= '0;
            wlim_reg       <= '0;
            first_char_reg <= '0;
            prev_code_reg  <= '0;
            fresh_reg      <= 1'b0;
            ended_reg      <= 1'b1;
            sp_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            bit_buf_reg    <= bit_buf_next;
            bit_cnt_reg    <= bit_cnt_next;
            base_size_reg  <= base_size_next;
            code_width_reg <= code_width_next;
            nfc_reg        <= nfc_next;
            wlim_reg       <= wlim_next;
            first_char_reg <= first_char_next;
            prev_code_reg  <= prev_code_next;
            fresh_reg      <= fresh_next;
            ended_reg      <= ended_next;
            sp_reg         <= sp_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload and chain scratch
    always_ff @(posedge clk)
    begin
        incode_reg   <= incode_next;
        cur_code_reg <= cur_code_next;
        if (cmd.emit)
        begin
            out_status_reg <= cmd.status;
            case (cmd.pix_sel)
                gld_pkg::PIX_CODE:  out_pixel_reg <= code_val[7:0];
                gld_pkg::PIX_STACK: out_pixel_reg <= stk_rd_reg;
                default:            out_pixel_reg <= '0;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_pixel  = out_pixel_reg;

    `GLD_ASSERT_IMPLIES(a_emit_free, cmd.emit, out_free, "result written over a pending transfer")
    `GLD_ASSERT_ALWAYS(a_sp_bound, sp_reg <= TBL_END, "stack pointer past table size")
    `GLD_ASSERT_ALWAYS(a_bits_bound, bit_cnt_reg <= 6'd32, "bit count past buffer width")
    `GLD_ASSERT_IMPLIES(a_width_cap, !ended_reg, code_width_reg <= 4'(AW), "code width past limit")
    `GLD_ASSERT_NEXT(a_pop_dec, cmd.op == gld_pkg::OP_POP_RD, sp_reg == $past(sp_reg) - SW'(1), "pop did not lower stack pointer")

endmodule

FILE: rtl/core/gif_lzw_decoder_core.sv
// Channel  | Dir | Payload
// in_ch    | in  | kind, data_byte, min_code_size
// out_ch   | out | status, pixel_index
//
// Start, data and unused items are answered from S_IDLE. A read with stacked
// pixels reads the stack and emits from S_POP_WAIT. A read that decodes goes to
// S_DECODE for any clear codes and the code, then does a table read per chain
// entry, closes the chain and pops the first pixel. rst_n clears control state;
// the code table and stack are not cleared and need no pass. A stalled out_ch
// holds the block before it writes its next result.
module gif_lzw_decoder_core (
    input  logic clk,
    input  logic rst_n,
    gld_in_if.sink    in_ch,
    gld_out_if.source out_ch
);

    gld_pkg::dp_cmd_t  cmd;
    gld_pkg::dp_stat_t stat;

    gld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_kind  (in_ch.kind),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gld_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (in_ch.data_byte),
        .min_code_size (in_ch.min_code_size),
        .cmd           (cmd),
        .stat          (stat),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .out_status    (out_ch.status),
        .out_pixel     (out_ch.pixel_index)
    );

endmodule

FILE: verif/lzw_checker.sv
// Watches both channels, predicts every result of the decoder and compares.
module lzw_checker
    import gld_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    gld_in_if    in_mon,
    gld_out_if   out_mon,
    output int   fails,
    output int   pending,
    output int   pixels_seen,
    output bit   table_filled
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0] status;
        logic [7:0] pixel;
    } decode_res_t;

    decode_res_t expected_q[$];

    // decoder state mirror
    bit [31:0]  bit_buf;
    int         bit_cnt;
    int         root_bits;
    int         code_w;
    int         next_code;
    int         grow_at;
    int         first_pix;
    int         prev_code;
    int         stack_top;
    bit         fresh;
    bit         ended;
    logic [11:0] prefix_mem [0:TABLE_SIZE-1];
    logic [7:0]  suffix_mem [0:TABLE_SIZE-1];
    logic [7:0]  pixel_stack [0:TABLE_SIZE-1];

    function automatic void table_init();
        int clr;
        clr = 1 << root_bits;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            prefix_mem[i] = '0;
            suffix_mem[i] = (i < clr) ? 8'(i) : 8'd0;
        end
        code_w    = root_bits + 1;
        next_code = clr + 2;
        grow_at   = 2 * clr;
        stack_top = 0;
        fresh     = 1'b1;
    endfunction

    function automatic void stack_push(int v);
        if (stack_top < TABLE_SIZE)
        begin
            pixel_stack[stack_top] = 8'(v);
            stack_top++;
        end
    endfunction

    function automatic decode_res_t decode_item(logic [1:0] k, logic [7:0] b, logic [3:0] m);
        decode_res_t r;
        int clr;
        int c;
        int incode;
        int w;
        r.status = ST_ACCEPT;
        r.pixel  = 8'd0;
        if (k == KIND_START)
        begin
            if (m < 2 || m > 8)
            begin
                ended    = 1'b1;
                r.status = ST_BAD_SIZE;
                return r;
            end
            root_bits = int'(m);
            bit_buf   = '0;
            bit_cnt   = 0;
            first_pix = 0;
            prev_code = 0;
            table_init();
            ended = 1'b0;
            return r;
        end
        if (k == KIND_DATA)
        begin
            if (bit_cnt > 24)
            begin
                r.status = ST_FULL;
                return r;
            end
            bit_buf |= 32'(b) << bit_cnt;
            bit_cnt += 8;
            return r;
        end
        if (k == KIND_NONE)
            return r;
        // read
        if (ended)
        begin
            r.status = ST_END;
            return r;
        end
        if (stack_top > 0)
        begin
            stack_top--;
            r.status = ST_PIXEL;
            r.pixel  = pixel_stack[stack_top];
            return r;
        end
        while (1)
        begin
            w   = code_w;
            clr = 1 << root_bits;
            if (bit_cnt < w)
            begin
                r.status = ST_NEED;
                return r;
            end
            c = int'(bit_buf & ((32'd1 << w) - 1));
            bit_buf >>= w;
            bit_cnt -= w;
            if (c == clr)
            begin
                table_init();
                continue;
            end
            if (c == clr + 1 || (fresh && c > clr + 1) || (!fresh && c > next_code))
            begin
                r.status  = (c == clr + 1) ? ST_END : ST_BAD_CODE;
                ended     = 1'b1;
                stack_top = 0;
                return r;
            end
            if (fresh)
            begin
                fresh     = 1'b0;
                first_pix = c;
                prev_code = c;
                r.status  = ST_PIXEL;
                r.pixel   = 8'(c);
                return r;
            end
            incode = c;
            // code one past the table: string of previous code plus its first pixel
            if (c == next_code)
            begin
                stack_push(first_pix);
                c = prev_code;
            end
            while (c >= clr)
            begin
                c &= TABLE_SIZE - 1;
                stack_push(int'(suffix_mem[c]));
                c = int'(prefix_mem[c]);
            end
            first_pix = c & 8'hFF;
            stack_push(first_pix);
            if (next_code < TABLE_SIZE)
            begin
                prefix_mem[next_code] = 12'(prev_code);
                suffix_mem[next_code] = 8'(first_pix);
                next_code++;
                if (next_code >= grow_at && grow_at < TABLE_SIZE)
                begin
                    grow_at *= 2;
                    code_w++;
                end
                if (next_code == TABLE_SIZE)
                    table_filled = 1'b1;
            end
            prev_code = incode & (TABLE_SIZE - 1);
            stack_top--;
            r.status = ST_PIXEL;
            r.pixel  = pixel_stack[stack_top];
            return r;
        end
        return r;
    endfunction

    // predict on input transfer, compare on output transfer
    always @(posedge clk or negedge rst_n)
    begin
        decode_res_t got;
        decode_res_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            bit_buf = '0; bit_cnt = 0; root_bits = 0; code_w = 0; next_code = 0;
            grow_at = 0; first_pix = 0; prev_code = 0; stack_top = 0;
            fresh = 1'b0; ended = 1'b1;
            fails = 0; pending = 0; pixels_seen = 0; table_filled = 1'b0;
        end
        else
        begin
            if (in_mon.valid && in_mon.ready)
                expected_q.push_back(decode_item(in_mon.kind, in_mon.data_byte,
                                                 in_mon.min_code_size));
            if (out_mon.valid && out_mon.ready)
            begin
                got.status = out_mon.status;
                got.pixel  = out_mon.pixel_index;
                if (expected_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("ERROR: unexpected result status=%0d pixel=%0d",
                                 got.status, got.pixel);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.status == ST_PIXEL)
                        pixels_seen++;
                    if (got.status !== want.status || got.pixel !== want.pixel)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("ERROR: status exp %0d got %0d, pixel exp %0d got %0d",
                                     want.status, got.status, want.pixel, got.pixel);
                    end
                end
            end
            pending = expected_q.size();
        end
    end
endmodule

FILE: verif/tb.sv
module tb;
    import gld_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    int   pixels_seen;
    bit   table_filled;
    int   hold_asks;
    int   images;
    int   burst_left;

    gld_in_if  in_ch ();
    gld_out_if out_ch ();

    gif_lzw_decoder_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    lzw_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .fails        (fails),
        .pending      (pending),
        .pixels_seen  (pixels_seen),
        .table_filled (table_filled)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // receiver: stall rate is redrawn on a phase counter, plus long holds on request
    int hold_left;
    int hold_seen;
    int stall_pct;
    int phase_cnt;
    initial
    begin
        out_ch.ready <= 1'b0;
        hold_left = 0; hold_seen = 0; stall_pct = 0; phase_cnt = 0;
        forever
        begin
            @(posedge clk);
            phase_cnt++;
            if (phase_cnt % 300 == 0)
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // one transfer on the input channel, with random gaps between bursts
    task automatic send_item(logic [1:0] k, logic [7:0] b, logic [3:0] m);
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 15);
        end
        burst_left--;
        in_ch.kind          <= k;
        in_ch.data_byte     <= b;
        in_ch.min_code_size <= m;
        in_ch.valid         <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // encoder-side bookkeeping for building legal code streams
    bit stream_bits[$];
    int str_len [0:TABLE_SIZE-1];
    int held;
    int owed;

    task automatic push_bits_for(int code, int w);
        for (int i = 0; i < w; i++)
            stream_bits.push_back(code[i]);
        owed += w;
        while (held < owed)
        begin
            logic [7:0] b;
            for (int i = 0; i < 8; i++)
                b[i] = (stream_bits.size() > 0) ? stream_bits.pop_front()
                                                : 1'($urandom_range(0, 1));
            send_item(KIND_DATA, b, 4'($urandom));
            held += 8;
        end
    endtask

    // one image: start, ncodes codes, then an end code unless a bad code ends it
    task automatic send_image(int m, int ncodes, int root_pct, bit inject_bad);
        int clr;
        int w;
        int nf;
        int lim;
        int prev;
        int code;
        int npix;
        int hi;
        bit fresh;
        bit bad;
        send_item(KIND_START, 8'($urandom), 4'(m));
        stream_bits.delete();
        held = 0; owed = 0;
        clr = 1 << m;
        w = m + 1; nf = clr + 2; lim = 2 * clr; fresh = 1'b1; prev = 0;
        for (int i = 0; i < clr; i++)
            str_len[i] = 1;
        images++;
        for (int n = 0; n < ncodes; n++)
        begin
            bad = 1'b0;
            hi = (nf < (1 << w) - 1) ? nf : (1 << w) - 1;
            if ($urandom_range(0, 99) < 3)
            begin
                // clear code resets the table and takes no read of its own
                push_bits_for(clr, w);
                w = m + 1; nf = clr + 2; lim = 2 * clr; fresh = 1'b1;
                continue;
            end
            if (fresh || $urandom_range(0, 99) < root_pct)
                code = $urandom_range(0, clr - 1);
            else if (inject_bad && $urandom_range(0, 29) == 0 && nf < (1 << w) - 1)
            begin
                code = $urandom_range(nf + 1, (1 << w) - 1);
                bad = 1'b1;
            end
            else
                code = $urandom_range(clr + 2, hi);
            push_bits_for(code, w);
            if (bad)
            begin
                send_item(KIND_READ, 8'($urandom), 4'($urandom));
                return;
            end
            if (fresh)
                npix = 1;
            else
                npix = (code == nf) ? str_len[prev] + 1 : str_len[code];
            if (!fresh && nf < TABLE_SIZE)
            begin
                str_len[nf] = str_len[prev] + 1;
                nf++;
                if (nf >= lim && lim < TABLE_SIZE)
                begin
                    lim *= 2;
                    w++;
                end
            end
            fresh = 1'b0;
            prev = code;
            held -= owed;
            owed = 0;
            repeat (npix) send_item(KIND_READ, 8'($urandom), 4'($urandom));
        end
        push_bits_for(clr + 1, w);
        held -= owed;
        owed = 0;
        repeat ($urandom_range(1, 2)) send_item(KIND_READ, 8'($urandom), 4'($urandom));
    endtask

    initial
    begin
        in_ch.valid         <= 1'b0;
        in_ch.kind          <= KIND_NONE;
        in_ch.data_byte     <= 8'd0;
        in_ch.min_code_size <= 4'd0;
        rst_n = 1'b0;
        hold_asks = 0; images = 0; burst_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: read before any start, bad sizes, unused kind
        send_item(KIND_READ, 8'h00, 4'h0);
        send_item(KIND_START, 8'h00, 4'd0);
        send_item(KIND_START, 8'hFF, 4'd1);
        send_item(KIND_START, 8'h00, 4'd9);
        send_item(KIND_START, 8'h00, 4'd15);
        send_item(KIND_NONE, 8'hFF, 4'hF);
        // valid size, then not enough bits, then buffer full
        send_item(KIND_START, 8'h00, 4'd8);
        send_item(KIND_READ, 8'h00, 4'd0);
        send_item(KIND_DATA, 8'hFF, 4'd0);
        send_item(KIND_DATA, 8'h00, 4'd0);
        send_item(KIND_DATA, 8'hFF, 4'd0);
        send_item(KIND_DATA, 8'hA5, 4'd0);
        send_item(KIND_DATA, 8'h5A, 4'd0);
        // first code not a root is a bad code (size 2: code 6 in 3 bits)
        send_item(KIND_START, 8'h00, 4'd2);
        send_item(KIND_DATA, 8'h06, 4'd0);
        send_item(KIND_READ, 8'h00, 4'd0);
        send_item(KIND_READ, 8'h00, 4'd0);
        send_item(KIND_DATA, 8'h3C, 4'd0);
        // short images at the extreme sizes
        send_image(2, 8, 50, 1'b0);
        send_image(8, 8, 50, 1'b0);

        // random images, with long receiver hold and a full drain along the way
        for (int i = 0; i < 8; i++)
        begin
            if (i == 3)
                hold_asks++;
            if (i == 6)
            begin
                in_ch.valid <= 1'b0;
                burst_left = 1;
                @(posedge clk);
                wait (pending == 0);
                @(posedge clk);
            end
            send_image($urandom_range(2, 8), $urandom_range(5, 18), 40, 1'b1);
            // noise between images
            repeat ($urandom_range(0, 3))
                send_item(2'($urandom), 8'($urandom), 4'($urandom));
        end
        send_image($urandom_range(2, 8), 20, 40, 1'b1);

        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (100) @(posedge clk);
        $display("Covered %0d images, %0d pixels, table filled: %0d", images,
                 pixels_seen, table_filled);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
